FILE: rtl/spt_pkg.sv
package spt_pkg;

    localparam int NUM_POINTS_DEF = 32;
    localparam int NUM_BASES_DEF  = 8;

    typedef enum logic [2:0] {
        FUNC_ALLOC = 3'd0,
        FUNC_FREE  = 3'd1,
        FUNC_ADD   = 3'd2,
        FUNC_SET   = 3'd3,
        FUNC_CHECK = 3'd4,
        FUNC_READ  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_POINT = 2'd1,
        ST_NO_BASE  = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    // register select is paddr[2]
    typedef enum logic {
        REG_POINTS = 1'b0,
        REG_BASES  = 1'b1
    } t_reg;

    typedef struct packed {
        t_func       func;
        logic [4:0]  slot;
        logic        want_base;
        logic        client_managed_request;
        logic [31:0] amount;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [4:0]  slot_out;
        logic [2:0]  base_out;
        logic        has_base_out;
        logic [31:0] current_value;
        logic [31:0] target_value;
        logic        expired;
    } t_out;

endpackage

FILE: rtl/sync_point_table_core.sv
// channel | valid      | stall      | beat
// --------+------------+------------+--------------------
// in      | i_in_valid | o_in_stall | i_in_data  (t_in)
// out     | o_out_valid| i_out_stall| o_out_data (t_out)
// cfg     | APB write/read, points_in_use at 0x0, bases_in_use at 0x4
//
// One beat per cycle while o_in_stall is low: the table is read, updated and
// the result registered in the accept cycle, into the skid if the output stalls.
// A one-entry skid behind the result register absorbs one beat of output stall;
// o_in_stall rises only while that skid is full.
// Synchronous reset clears the table with point 0 reserved; no clearing pass.
module sync_point_table_core #(
    parameter int NUM_POINTS = spt_pkg::NUM_POINTS_DEF,
    parameter int NUM_BASES  = spt_pkg::NUM_BASES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  spt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spt_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int PIW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int BIW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;

    logic [5:0]            r_points_in_use;
    logic [3:0]            r_bases_in_use;
    logic [NUM_POINTS-1:0] r_taken;
    logic [NUM_POINTS-1:0] r_client;
    logic [NUM_POINTS-1:0] r_has_base;
    logic [BIW-1:0]        r_base_idx [NUM_POINTS];
    logic [NUM_BASES-1:0]  r_base_taken;
    logic [31:0]           r_current [NUM_POINTS];
    logic [31:0]           r_target [NUM_POINTS];

    logic                  r_out_valid;
    spt_pkg::t_out         r_out;
    logic                  r_skid_valid;
    spt_pkg::t_out         r_skid;

    logic [5:0]     eff_points;
    logic [3:0]     eff_bases;
    logic           free_found;
    logic [PIW-1:0] free_idx;
    logic           base_found;
    logic [BIW-1:0] base_idx;
    logic           in_accept;
    logic           out_take;
    logic           out_room;
    logic           slot_bad;
    logic [PIW-1:0] idx;
    logic [31:0]    cur_rd;
    logic [31:0]    tgt_rd;
    logic [31:0]    cur_diff;
    logic [31:0]    tgt_diff;
    logic           alloc_ok;
    spt_pkg::t_out  res;

    assign pready = 1'b1;

    assign eff_points = (32'(r_points_in_use) > NUM_POINTS) ? 6'(NUM_POINTS) : r_points_in_use;
    assign eff_bases  = (32'(r_bases_in_use) > NUM_BASES) ? 4'(NUM_BASES) : r_bases_in_use;

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign out_room   = !r_out_valid || out_take;
    assign o_in_stall = r_skid_valid;

    // lowest free point and lowest free base under the configured counts
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = NUM_POINTS - 1; k >= 0; k--) begin
            if (!r_taken[k] && (k < int'(eff_points))) begin
                free_found = 1'b1;
                free_idx   = PIW'(k);
            end
        end
    end

    always_comb begin
        base_found = 1'b0;
        base_idx   = '0;
        for (int k = NUM_BASES - 1; k >= 0; k--) begin
            if (!r_base_taken[k] && (k < int'(eff_bases))) begin
                base_found = 1'b1;
                base_idx   = BIW'(k);
            end
        end
    end

    assign slot_bad = ({1'b0, i_in_data.slot} >= eff_points);
    assign idx      = (i_in_data.func == spt_pkg::FUNC_ALLOC) ? free_idx : PIW'(i_in_data.slot);
    assign cur_rd   = r_current[idx];
    assign tgt_rd   = r_target[idx];
    assign cur_diff = cur_rd - i_in_data.amount;
    assign tgt_diff = tgt_rd - i_in_data.amount;
    assign alloc_ok = free_found && (!i_in_data.want_base || base_found);

    always_comb begin
        res = '0;
        res.status        = spt_pkg::ST_OK;
        res.slot_out      = i_in_data.slot;
        res.has_base_out  = r_has_base[idx];
        res.base_out      = r_has_base[idx] ? 3'(r_base_idx[idx]) : 3'd0;
        res.current_value = cur_rd;
        res.target_value  = tgt_rd;
        res.expired       = 1'b0;
        unique case (i_in_data.func)
            spt_pkg::FUNC_ALLOC: begin
                res.slot_out     = 5'(free_idx);
                res.has_base_out = i_in_data.want_base;
                res.base_out     = i_in_data.want_base ? 3'(base_idx) : 3'd0;
            end
            spt_pkg::FUNC_FREE: begin
                res.has_base_out = 1'b0;
                res.base_out     = 3'd0;
            end
            spt_pkg::FUNC_ADD: begin
                res.target_value = tgt_rd + i_in_data.amount;
            end
            spt_pkg::FUNC_SET: begin
                res.current_value = i_in_data.amount;
            end
            spt_pkg::FUNC_CHECK: begin
                res.expired = r_client[idx] ? !cur_diff[31] : (tgt_diff >= cur_diff);
            end
            default: begin
            end
        endcase
        priority if (i_in_data.func == spt_pkg::FUNC_ALLOC && !free_found) begin
            res        = '0;
            res.status = spt_pkg::ST_NO_POINT;
        end else if (i_in_data.func == spt_pkg::FUNC_ALLOC && !alloc_ok) begin
            res        = '0;
            res.status = spt_pkg::ST_NO_BASE;
        end else if (i_in_data.func != spt_pkg::FUNC_ALLOC && slot_bad) begin
            res        = '0;
            res.status = spt_pkg::ST_RANGE;
        end else begin
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= 6'd32;
            r_bases_in_use  <= 4'd8;
        end else if (psel && penable && pwrite) begin
            unique case (spt_pkg::t_reg'(paddr[2]))
                spt_pkg::REG_POINTS: r_points_in_use <= pwdata[5:0];
                spt_pkg::REG_BASES:  r_bases_in_use  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (spt_pkg::t_reg'(paddr[2]))
            spt_pkg::REG_POINTS: prdata = 32'(r_points_in_use);
            spt_pkg::REG_BASES:  prdata = 32'(r_bases_in_use);
            default:             prdata = '0;
        endcase
    end

    // table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken      <= NUM_POINTS'(1);
            r_client     <= '0;
            r_has_base   <= '0;
            r_base_taken <= '0;
            for (int k = 0; k < NUM_POINTS; k++) begin
                r_base_idx[k] <= '0;
                r_current[k]  <= '0;
                r_target[k]   <= '0;
            end
        end else if (in_accept) begin
            unique case (i_in_data.func)
                spt_pkg::FUNC_ALLOC: begin
                    if (alloc_ok) begin
                        r_taken[idx]    <= 1'b1;
                        r_client[idx]   <= i_in_data.client_managed_request;
                        r_has_base[idx] <= i_in_data.want_base;
                        r_base_idx[idx] <= i_in_data.want_base ? base_idx : '0;
                        if (i_in_data.want_base) begin
                            r_base_taken[base_idx] <= 1'b1;
                        end
                    end
                end
                spt_pkg::FUNC_FREE: begin
                    if (!slot_bad) begin
                        if (r_has_base[idx]) begin
                            r_base_taken[r_base_idx[idx]] <= 1'b0;
                        end
                        r_taken[idx]    <= 1'b0;
                        r_client[idx]   <= 1'b0;
                        r_has_base[idx] <= 1'b0;
                        r_base_idx[idx] <= '0;
                    end
                end
                spt_pkg::FUNC_ADD: begin
                    if (!slot_bad) begin
                        r_target[idx] <= res.target_value;
                    end
                end
                spt_pkg::FUNC_SET: begin
                    if (!slot_bad) begin
                        r_current[idx] <= i_in_data.amount;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (out_room) begin
            r_out_valid <= in_accept;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (out_room) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/spt_checker.sv
module spt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input spt_pkg::t_out o_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped under stall");

    // input stall only follows a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != spt_pkg::ST_OK |->
            o_out_data.current_value == 32'd0 && o_out_data.target_value == 32'd0 &&
            o_out_data.slot_out == 5'd0 && !o_out_data.has_base_out)
        else $error("failed operation carries payload");

    a_exp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.expired |-> o_out_data.status == spt_pkg::ST_OK)
        else $error("expired flag on failed operation");

    a_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_base_out |-> o_out_data.base_out == 3'd0)
        else $error("base index shown without a base");

endmodule

bind sync_point_table_core spt_checker u_spt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // func codes past the defined set; the block treats them as a read
    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 62;

    class point_table_ledger;
        logic [5:0]    points_reg;
        logic [3:0]    bases_reg;
        bit            taken[spt_pkg::NUM_POINTS_DEF];
        bit            client[spt_pkg::NUM_POINTS_DEF];
        bit            has_base[spt_pkg::NUM_POINTS_DEF];
        logic [2:0]    base_idx[spt_pkg::NUM_POINTS_DEF];
        bit            base_used[spt_pkg::NUM_BASES_DEF];
        logic [31:0]   cur[spt_pkg::NUM_POINTS_DEF];
        logic [31:0]   tgt[spt_pkg::NUM_POINTS_DEF];
        spt_pkg::t_out replies[$];
        int            errors;
        int            checked;

        function new();
            points_reg = 6'd32;
            bases_reg  = 4'd8;
            for (int k = 0; k < spt_pkg::NUM_POINTS_DEF; k++) begin
                taken[k]    = 1'b0;
                client[k]   = 1'b0;
                has_base[k] = 1'b0;
                base_idx[k] = 3'd0;
                cur[k]      = 32'd0;
                tgt[k]      = 32'd0;
            end
            for (int k = 0; k < spt_pkg::NUM_BASES_DEF; k++) begin
                base_used[k] = 1'b0;
            end
            // point 0 comes out of reset reserved
            taken[0] = 1'b1;
            errors   = 0;
            checked  = 0;
        endfunction

        function int live_points();
            return (points_reg > spt_pkg::NUM_POINTS_DEF) ? spt_pkg::NUM_POINTS_DEF
                                                          : int'(points_reg);
        endfunction

        function int live_bases();
            return (bases_reg > spt_pkg::NUM_BASES_DEF) ? spt_pkg::NUM_BASES_DEF
                                                        : int'(bases_reg);
        endfunction

        function void write_reg(spt_pkg::t_reg r, logic [31:0] v);
            if (r == spt_pkg::REG_POINTS) begin
                points_reg = v[5:0];
            end else begin
                bases_reg = v[3:0];
            end
        endfunction

        function spt_pkg::t_out predict_op(spt_pkg::t_in x);
            spt_pkg::t_out r;
            int            np;
            int            nb;
            int            i;
            int            b;
            logic [31:0]   cd;
            logic [31:0]   fd;
            logic [2:0]    fc;
            r  = '0;
            fc = x.func;
            np = live_points();
            nb = live_bases();
            if (fc == spt_pkg::FUNC_ALLOC) begin
                i = 0;
                while (i < np && taken[i]) i++;
                if (i >= np) begin
                    r.status = spt_pkg::ST_NO_POINT;
                    return r;
                end
                b = 0;
                if (x.want_base) begin
                    while (b < nb && base_used[b]) b++;
                    if (b >= nb) begin
                        r.status = spt_pkg::ST_NO_BASE;
                        return r;
                    end
                    base_used[b] = 1'b1;
                end
                taken[i]    = 1'b1;
                client[i]   = x.client_managed_request;
                has_base[i] = x.want_base;
                base_idx[i] = x.want_base ? 3'(b) : 3'd0;
            end else if (int'(x.slot) >= np) begin
                r.status = spt_pkg::ST_RANGE;
                return r;
            end else begin
                i = int'(x.slot);
                case (fc)
                    spt_pkg::FUNC_FREE: begin
                        if (has_base[i]) base_used[base_idx[i]] = 1'b0;
                        taken[i]    = 1'b0;
                        client[i]   = 1'b0;
                        has_base[i] = 1'b0;
                        base_idx[i] = 3'd0;
                    end
                    spt_pkg::FUNC_ADD: tgt[i] = tgt[i] + x.amount;
                    spt_pkg::FUNC_SET: cur[i] = x.amount;
                    spt_pkg::FUNC_CHECK: begin
                        cd = cur[i] - x.amount;
                        fd = tgt[i] - x.amount;
                        // client-managed points only look at the sign of the distance
                        r.expired = client[i] ? !cd[31] : (fd >= cd);
                    end
                    default: ;
                endcase
            end
            r.status        = spt_pkg::ST_OK;
            r.slot_out      = 5'(i);
            r.base_out      = has_base[i] ? base_idx[i] : 3'd0;
            r.has_base_out  = has_base[i];
            r.current_value = cur[i];
            r.target_value  = tgt[i];
            return r;
        endfunction

        function void note_beat(spt_pkg::t_in x);
            replies.push_back(predict_op(x));
        endfunction

        function void compare(string tag, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, e, a);
                errors++;
            end
        endfunction

        function void check_beat(spt_pkg::t_out got);
            spt_pkg::t_out want;
            if (replies.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = replies.pop_front();
            checked++;
            compare("status", 32'(want.status), 32'(got.status));
            compare("slot_out", 32'(want.slot_out), 32'(got.slot_out));
            compare("base_out", 32'(want.base_out), 32'(got.base_out));
            compare("has_base_out", 32'(want.has_base_out), 32'(got.has_base_out));
            compare("current_value", want.current_value, got.current_value);
            compare("target_value", want.target_value, got.target_value);
            compare("expired", 32'(want.expired), 32'(got.expired));
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    spt_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    spt_pkg::t_out o_out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    point_table_ledger ledger;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int beats_sent = 0;
    int allocs_sent = 0;
    int checks_sent = 0;
    int settings_used = 0;

    sync_point_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: take beats, and stall on a pattern that changes every so often
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            ledger.check_beat(o_out_data);
        end
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 120);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ((stall_span % 7) < 3);
        endcase
    end

    task automatic send_beat(spt_pkg::t_in item);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ledger.note_beat(item);
        beats_sent++;
        if (item.func == spt_pkg::FUNC_ALLOC) allocs_sent++;
        if (item.func == spt_pkg::FUNC_CHECK) checks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic issue(logic [2:0] f, logic [4:0] s, bit wb, bit cm, logic [31:0] amt);
        spt_pkg::t_in item;
        item.func                   = spt_pkg::t_func'(f);
        item.slot                   = s;
        item.want_base              = wb;
        item.client_managed_request = cm;
        item.amount                 = amt;
        send_beat(item);
    endtask

    // hold input until every predicted result is back, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (ledger.replies.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(spt_pkg::t_reg r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        ledger.write_reg(r, v);
        // read back through a fresh setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== v) begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, r, v, prdata);
            ledger.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [5:0] points, logic [3:0] bases);
        drain();
        apb_write(spt_pkg::REG_POINTS, 32'(points));
        apb_write(spt_pkg::REG_BASES, 32'(bases));
        settings_used++;
    endtask

    task automatic random_beats(int count);
        spt_pkg::t_in item;
        int           np;
        int           pick;
        int           tries;
        np = ledger.live_points();
        repeat (count) begin
            pick = $urandom_range(0, 99);
            item.want_base              = 1'($urandom_range(0, 1));
            item.client_managed_request = 1'($urandom_range(0, 1));
            item.amount                 = $urandom;
            item.slot = (np > 0 && $urandom_range(0, 4) != 0) ? 5'($urandom_range(0, np - 1))
                                                              : 5'($urandom_range(0, 31));
            if (pick < 26) begin
                item.func = spt_pkg::FUNC_ALLOC;
            end else if (pick < 40) begin
                item.func = spt_pkg::FUNC_FREE;
                // aim mostly at held points so the table keeps turning over
                for (tries = 0; tries < 8 && np > 0 && !ledger.taken[item.slot]; tries++) begin
                    item.slot = 5'($urandom_range(0, np - 1));
                end
            end else if (pick < 54) begin
                item.func = spt_pkg::FUNC_ADD;
                if ($urandom_range(0, 1) == 1) item.amount = 32'($urandom_range(0, 16));
            end else if (pick < 68) begin
                item.func = spt_pkg::FUNC_SET;
                if ($urandom_range(0, 1) == 1) begin
                    item.amount = ledger.tgt[item.slot] + 32'($urandom_range(0, 8)) - 32'd4;
                end
            end else if (pick < 88) begin
                item.func = spt_pkg::FUNC_CHECK;
                // place the threshold near the counters and near the sign boundary
                case ($urandom_range(0, 3))
                    0: item.amount = ledger.cur[item.slot] + 32'($urandom_range(0, 8)) - 32'd4;
                    1: item.amount = ledger.tgt[item.slot] + 32'($urandom_range(0, 8)) - 32'd4;
                    2: item.amount = ledger.cur[item.slot] + 32'h8000_0000
                                     + 32'($urandom_range(0, 2)) - 32'd1;
                    default: ;
                endcase
            end else if (pick < 95) begin
                item.func = spt_pkg::FUNC_READ;
            end else begin
                item.func = ($urandom_range(0, 1) == 1) ? spt_pkg::t_func'(FUNC_SPARE_A)
                                                        : spt_pkg::t_func'(FUNC_SPARE_B);
            end
            send_beat(item);
        end
    endtask

    logic [5:0] plan_points[PHASES] = '{6'd63, 6'd1, 6'd0, 6'd7, 6'd32, 6'd20, 6'd2, 6'd32};
    logic [3:0] plan_bases[PHASES]  = '{4'd15, 4'd1, 4'd0, 4'd2, 4'd8, 4'd3, 4'd15, 4'd0};

    initial begin
        ledger = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: reserved point, wrap of the target, both expiry rules
        issue(spt_pkg::FUNC_READ,  5'd0,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_ALLOC, 5'd0,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_ALLOC, 5'd0,  1'b1, 1'b1, 32'd0);
        issue(spt_pkg::FUNC_ADD,   5'd1,  1'b0, 1'b0, 32'hFFFF_FFFF);
        issue(spt_pkg::FUNC_ADD,   5'd1,  1'b0, 1'b0, 32'd2);
        issue(spt_pkg::FUNC_SET,   5'd1,  1'b0, 1'b0, 32'h8000_0000);
        issue(spt_pkg::FUNC_CHECK, 5'd1,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_CHECK, 5'd1,  1'b0, 1'b0, 32'd2);
        issue(spt_pkg::FUNC_SET,   5'd2,  1'b0, 1'b0, 32'h7FFF_FFFF);
        issue(spt_pkg::FUNC_CHECK, 5'd2,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_CHECK, 5'd2,  1'b0, 1'b0, 32'hFFFF_FFFF);
        issue(spt_pkg::FUNC_FREE,  5'd2,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_SET,   5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF);
        issue(spt_pkg::FUNC_ADD,   5'd31, 1'b0, 1'b0, 32'h1234_5678);
        issue(spt_pkg::FUNC_FREE,  5'd5,  1'b0, 1'b0, 32'd0);
        issue(FUNC_SPARE_A, 5'd1,  1'b0, 1'b0, 32'd0);
        issue(FUNC_SPARE_B, 5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF);
        issue(spt_pkg::FUNC_FREE,  5'd0,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_ALLOC, 5'd0,  1'b1, 1'b1, 32'd0);

        // tight table: no free base, no free point, slots past the limit
        set_config(6'd3, 4'd1);
        issue(spt_pkg::FUNC_ALLOC, 5'd0,  1'b1, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_ALLOC, 5'd0,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_ALLOC, 5'd0,  1'b0, 1'b1, 32'd0);
        issue(spt_pkg::FUNC_READ,  5'd3,  1'b0, 1'b0, 32'd0);
        issue(spt_pkg::FUNC_CHECK, 5'd31, 1'b0, 1'b0, 32'hFFFF_FFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_config(plan_points[ph], plan_bases[ph]);
            random_beats(BEATS_PER_PHASE);
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("testbench: %0d beats sent, %0d results checked, %0d register settings",
                 beats_sent, ledger.checked, settings_used);
        $display("testbench: %0d allocations and %0d expiry checks among them, %0d errors",
                 allocs_sent, checks_sent, ledger.errors);
        if (ledger.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
